// ===== sv/ptms_pkg.sv =====
package ptms_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int COORD_WIDTH = 16;

    // derived widths
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int POINT_W = 2 * COORD_WIDTH;
    localparam int PROD_W  = 2 * COORD_WIDTH;
    localparam int DIST_W  = 2 * COORD_WIDTH + 1;

    // action codes
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // input transaction
    typedef struct packed {
        logic [1:0]                    action;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } t_item;

    // result transaction
    typedef struct packed {
        logic                          found;
        logic [CNT_W-1:0]              match_index;
        logic signed [COORD_WIDTH-1:0] echo_x;
        logic signed [COORD_WIDTH-1:0] echo_y;
    } t_result;

    // table access between sequencer and storage
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [POINT_W-1:0] point;
        logic [DIST_W-1:0]  distance;
    } t_wr_req;

    typedef struct packed {
        logic [POINT_W-1:0] point;
        logic [DIST_W-1:0]  distance;
    } t_entry;

endpackage

// ===== sv/ptms_table.sv =====
module ptms_table (
    input  logic             i_clk,
    input  ptms_pkg::t_wr_req i_wr,
    input  ptms_pkg::t_rd_req i_rd,
    output ptms_pkg::t_entry  o_rd_data
);

    logic [ptms_pkg::POINT_W-1:0] r_point_mem [ptms_pkg::TABLE_DEPTH];
    logic [ptms_pkg::DIST_W-1:0]  r_dist_mem  [ptms_pkg::TABLE_DEPTH];
    ptms_pkg::t_entry             r_rd_data;

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_point_mem[i_wr.addr] <= i_wr.point;
            r_dist_mem[i_wr.addr]  <= i_wr.distance;
        end
        if (i_rd.en) begin
            r_rd_data.point    <= r_point_mem[i_rd.addr];
            r_rd_data.distance <= r_dist_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/ptms_ctrl.sv =====
module ptms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ptms_pkg::t_item   i_item,
    input  logic              i_ordered,
    input  ptms_pkg::t_entry  i_rd_data,
    output logic              o_busy,
    output ptms_pkg::t_rd_req o_rd,
    output ptms_pkg::t_wr_req o_wr,
    output logic              o_res_valid,
    output ptms_pkg::t_result o_res
);

    localparam int CW = ptms_pkg::COORD_WIDTH;
    localparam int NW = ptms_pkg::CNT_W;
    localparam int AW = ptms_pkg::IDX_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SQX     = 4'd1;
    localparam logic [3:0] S_SQY     = 4'd2;
    localparam logic [3:0] S_APPEND  = 4'd3;
    localparam logic [3:0] S_LSCAN   = 4'd4;
    localparam logic [3:0] S_BLOOP   = 4'd5;
    localparam logic [3:0] S_BCMP    = 4'd6;
    localparam logic [3:0] S_FLO     = 4'd7;
    localparam logic [3:0] S_FLO_CMP = 4'd8;
    localparam logic [3:0] S_FHI     = 4'd9;
    localparam logic [3:0] S_FHI_CMP = 4'd10;

    logic [3:0]                   r_state, n_state;
    logic [1:0]                   r_act, n_act;
    logic signed [CW-1:0]         r_x, n_x;
    logic signed [CW-1:0]         r_y, n_y;
    logic [NW-1:0]                r_count, n_count;
    logic [NW-1:0]                r_ptr, n_ptr;
    logic [NW-1:0]                r_lo, n_lo;
    logic [NW-1:0]                r_hi, n_hi;
    logic [NW-1:0]                r_mid, n_mid;
    logic                         r_pend, n_pend;
    logic [ptms_pkg::DIST_W-1:0]  r_acc, n_acc;

    logic [CW-1:0]                sq_op;
    logic [ptms_pkg::PROD_W-1:0]  prod;
    logic                         pt_eq;
    logic                         dist_lt;
    logic                         dist_gt;
    logic [NW:0]                  mid_sum;
    logic [NW-1:0]                span;
    logic                         fin;
    logic                         fin_found;
    logic [NW-1:0]                fin_idx;

    // shared squaring unit: |x| in the first pass, |y| in the second
    always_comb begin
        if (r_state == S_SQX) begin
            sq_op = r_x[CW-1] ? ($unsigned(~r_x) + 1'b1) : $unsigned(r_x);
        end else begin
            sq_op = r_y[CW-1] ? ($unsigned(~r_y) + 1'b1) : $unsigned(r_y);
        end
        prod = sq_op * sq_op;
    end

    // shared compare unit against the registered table read
    assign pt_eq   = (i_rd_data.point == {r_x, r_y});
    assign dist_lt = (i_rd_data.distance < r_acc);
    assign dist_gt = (i_rd_data.distance > r_acc);

    // binary search midpoint and window size
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign span    = r_hi - r_lo;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_x       = r_x;
        n_y       = r_y;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_pend    = r_pend;
        n_acc     = r_acc;
        o_rd      = '0;
        o_wr      = '0;
        fin       = 1'b0;
        fin_found = 1'b0;
        fin_idx   = r_count;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_act = i_item.action;
                    n_x   = i_item.point_x;
                    n_y   = i_item.point_y;
                    unique case (i_item.action)
                        ptms_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        ptms_pkg::ACT_APPEND: begin
                            n_state = S_SQX;
                        end
                        ptms_pkg::ACT_QUERY: begin
                            n_lo   = '0;
                            n_hi   = r_count;
                            n_ptr  = r_count;
                            n_pend = 1'b0;
                            n_state = i_ordered ? S_SQX : S_LSCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SQX: begin
                n_acc   = {1'b0, prod};
                n_state = S_SQY;
            end
            S_SQY: begin
                n_acc   = r_acc + {1'b0, prod};
                n_state = (r_act == ptms_pkg::ACT_APPEND) ? S_APPEND : S_BLOOP;
            end
            S_APPEND: begin
                if (r_count < NW'(ptms_pkg::TABLE_DEPTH)) begin
                    o_wr.en       = 1'b1;
                    o_wr.addr     = r_count[AW-1:0];
                    o_wr.point    = {r_x, r_y};
                    o_wr.distance = r_acc;
                    n_count       = r_count + 1'b1;
                end
                n_state = S_IDLE;
            end
            // reverse scan: issue one read per cycle, compare the previous one
            S_LSCAN: begin
                if (r_pend && pt_eq) begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_idx   = r_mid;
                end else if (r_ptr == '0) begin
                    fin = 1'b1;
                end else begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = AW'(r_ptr - 1'b1);
                    n_mid     = r_ptr - 1'b1;
                    n_ptr     = r_ptr - 1'b1;
                    n_pend    = 1'b1;
                end
            end
            S_BLOOP: begin
                if (span > NW'(1)) begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = mid_sum[AW:1];
                    n_mid     = mid_sum[NW:1];
                    n_state   = S_BCMP;
                end else begin
                    n_state = S_FLO;
                end
            end
            S_BCMP: begin
                if (dist_lt) begin
                    n_lo    = r_mid;
                    n_state = S_BLOOP;
                end else if (dist_gt) begin
                    n_hi    = r_mid;
                    n_state = S_BLOOP;
                end else begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_idx   = r_mid;
                end
            end
            // final exact checks of the low and high bounds
            S_FLO: begin
                if (r_lo < r_count) begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = r_lo[AW-1:0];
                    n_state   = S_FLO_CMP;
                end else begin
                    n_state = S_FHI;
                end
            end
            S_FLO_CMP: begin
                if (pt_eq) begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_idx   = r_lo;
                end else begin
                    n_state = S_FHI;
                end
            end
            S_FHI: begin
                if (r_hi < r_count) begin
                    o_rd.en   = 1'b1;
                    o_rd.addr = r_hi[AW-1:0];
                    n_state   = S_FHI_CMP;
                end else begin
                    fin = 1'b1;
                end
            end
            S_FHI_CMP: begin
                fin = 1'b1;
                if (pt_eq) begin
                    fin_found = 1'b1;
                    fin_idx   = r_hi;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state = S_IDLE;
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_act <= n_act;
        r_x   <= n_x;
        r_y   <= n_y;
        r_ptr <= n_ptr;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_acc <= n_acc;
    end

    // finished query
    assign o_busy            = (r_state != S_IDLE);
    assign o_res_valid       = fin;
    assign o_res.found       = fin_found;
    assign o_res.match_index = fin_idx;
    assign o_res.echo_x      = fin_found ? r_x : '0;
    assign o_res.echo_y      = fin_found ? r_y : '0;

endmodule

// ===== sv/point_table_membership_search.sv =====
// Point table with membership search. A transaction is taken when start is high and busy
// is low; clear and unused codes leave busy low, and append makes two passes through the
// shared squaring multiplier and then one table write if the table is not full. A query
// in scan mode reads the table one entry per cycle through the single read port; a
// query in ordered mode squares the point and runs a binary search on distance, which
// ends on a probe that hits on distance or else in exact checks of the low and high
// bounds, and each probe is a registered read followed by a compare. The result shows
// on o_result for exactly one cycle with o_strobe high and must be taken then, as there
// is no way to stall it. The search mode register is to be written through the config
// channel only while the block is idle, which the block itself does not enforce.
module point_table_membership_search (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ptms_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output ptms_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    output logic              o_cfg_ready
);

    logic              r_ordered;
    logic              r_strobe;
    ptms_pkg::t_result r_result;
    logic              ctrl_busy;
    logic              res_valid;
    ptms_pkg::t_result res;
    ptms_pkg::t_rd_req rd_req;
    ptms_pkg::t_wr_req wr_req;
    ptms_pkg::t_entry  rd_data;

    // config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ordered <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ordered <= i_cfg_data;
        end
    end

    // sequencer with shared multiplier and compare
    ptms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start && !ctrl_busy),
        .i_item      (i_item),
        .i_ordered   (r_ordered),
        .i_rd_data   (rd_data),
        .o_busy      (ctrl_busy),
        .o_rd        (rd_req),
        .o_wr        (wr_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // point and distance storage
    ptms_table u_table (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= res_valid;
        end
        if (res_valid) begin
            r_result <= res;
        end
    end

    assign busy     = ctrl_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== sv/ptms_checker.sv =====
module ptms_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input ptms_pkg::t_item   i_item,
    input logic              busy,
    input logic              o_strobe,
    input ptms_pkg::t_result o_result
);

    // a result ends its query and returns the block to idle, so strobes never come back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe on two consecutive cycles");

    // a miss carries zero echo coordinates
    a_miss_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.found) |-> (o_result.echo_x == '0 && o_result.echo_y == '0))
        else $error("miss result with nonzero echo");

    // an accepted query keeps the block busy in the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ptms_pkg::ACT_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    // transactions other than a query never produce a result right after
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action != ptms_pkg::ACT_QUERY) |=> !o_strobe)
        else $error("result strobe after a non-query transaction");

endmodule

bind point_table_membership_search ptms_checker u_ptms_checker (.*);
